// File: hdl/idll_pkg.sv
// Package for the indexed doubly linked list: request and result structs,
// function codes, status codes and the default table size.
// No dependencies.
`timescale 1ns / 1ps

package idll_pkg;

    localparam int DEF_SLOTS = 16;

    localparam int FUNC_W  = 3;
    localparam int KEY_W   = 31;
    localparam int PLATE_W = 56;
    localparam int CLASS_W = 2;
    localparam int STAT_W  = 3;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;

    // Function codes.
    localparam logic [FUNC_W-1:0] FN_INS_HEAD  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_TAIL  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INS_AFTER = 3'd2;
    localparam logic [FUNC_W-1:0] FN_RM_HEAD   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_RM_TAIL   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_RM_KEY    = 3'd5;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_BADKEY   = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [KEY_W-1:0]   new_key;
        logic [KEY_W-1:0]   anchor_key;
        logic [PLATE_W-1:0] plate_payload;
        logic [CLASS_W-1:0] vehicle_class;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [SLOT_W-1:0]  slot_touched;
        logic [COUNT_W-1:0] entry_count;
    } t_rsp;

endpackage

// File: hdl/indexed_doubly_linked_list.sv
// Indexed doubly linked list kept in a slot table held in one synchronous RAM.
// Depends on idll_pkg for the request/result structs and the codes.
// Link updates of neighbour entries go through read-modify-write sequences on that RAM.
//
//  Channel   Ports                      Direction  Transfer
//  request   start, busy, i_req         in         start high and busy low
//  result    o_valid, o_rsp             out        o_valid high for one cycle
//
// Rejected requests (full, bad key, empty, unknown function) answer in the next cycle.
// Others pass through a free-slot scan for inserts, a walk along the links for
// insert-after and remove-by-key, and the link-patch states that rewrite the
// neighbouring entries before the result strobe.
// Reset clears head, tail, count and the per-slot occupancy bits.
// The receiver cannot stall; busy drops in the cycle that carries the result strobe.
`timescale 1ns / 1ps

module indexed_doubly_linked_list
    import idll_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_valid,
    output t_rsp o_rsp
);

    localparam int IW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [LW-1:0] NIL = LW'(SLOTS);

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [PLATE_W-1:0] plate;
        logic [CLASS_W-1:0] vclass;
        logic [LW-1:0]      next;
        logic [LW-1:0]      prev;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_WALK,
        S_INS,
        S_ANCH_WR,
        S_PATCH_RD,
        S_PATCH_WR,
        S_RM0,
        S_RM_P_WR,
        S_RM_N,
        S_RM_N_WR
    } t_state;

    function automatic logic is_nil(input logic [LW-1:0] link);
        return link >= NIL;
    endfunction

    // Slot table RAM.
    t_entry r_mem [SLOTS];
    t_entry r_rd_q;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;

    // Control state.
    t_state          r_state, n_state;
    logic [LW-1:0]   r_head, n_head;
    logic [LW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_count, n_count;
    logic [SLOTS-1:0] r_valid, n_valid;
    logic            r_valid_out, n_valid_out;

    // Working registers.
    t_req            r_req, n_req;
    logic [IW-1:0]   r_idx, n_idx;
    logic [IW-1:0]   r_steps, n_steps;
    logic [LW-1:0]   r_cur, n_cur;
    logic [IW-1:0]   r_pv, n_pv;
    logic [IW-1:0]   r_slot, n_slot;
    logic [IW-1:0]   r_paddr, n_paddr;
    logic            r_psel, n_psel;
    logic [LW-1:0]   r_p, n_p;
    logic [LW-1:0]   r_n, n_n;
    t_rsp            r_rsp, n_rsp;

    logic            fin;
    logic [STAT_W-1:0] fin_status;
    logic            fin_use_slot;
    logic            walk_hit;
    t_entry          new_ent;

    assign walk_hit = r_valid[r_cur[IW-1:0]] && (r_rd_q.key == r_req.anchor_key);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_valid     = r_valid;
        n_req       = r_req;
        n_idx       = r_idx;
        n_steps     = r_steps;
        n_cur       = r_cur;
        n_pv        = r_pv;
        n_slot      = r_slot;
        n_paddr     = r_paddr;
        n_psel      = r_psel;
        n_p         = r_p;
        n_n         = r_n;
        rd_en       = 1'b0;
        rd_addr     = r_cur[IW-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_pv;
        wr_data     = r_rd_q;
        fin         = 1'b0;
        fin_status  = ST_OK;
        fin_use_slot = 1'b0;

        new_ent.key    = r_req.new_key;
        new_ent.plate  = r_req.plate_payload;
        new_ent.vclass = r_req.vehicle_class;
        new_ent.next   = NIL;
        new_ent.prev   = NIL;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    case (i_req.func)
                        FN_INS_HEAD, FN_INS_TAIL, FN_INS_AFTER: begin
                            if (r_count >= CW'(SLOTS)) begin
                                fin        = 1'b1;
                                fin_status = ST_FULL;
                            end else if (i_req.new_key == '0) begin
                                fin        = 1'b1;
                                fin_status = ST_BADKEY;
                            end else if (i_req.func == FN_INS_AFTER &&
                                         (i_req.anchor_key == '0 || is_nil(r_head))) begin
                                fin        = 1'b1;
                                fin_status = ST_NOTFOUND;
                            end else begin
                                n_idx   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        FN_RM_HEAD, FN_RM_TAIL, FN_RM_KEY: begin
                            if (r_count == '0 || is_nil(r_head)) begin
                                fin        = 1'b1;
                                fin_status = ST_EMPTY;
                            end else if (i_req.func == FN_RM_HEAD) begin
                                rd_en   = 1'b1;
                                rd_addr = r_head[IW-1:0];
                                n_cur   = r_head;
                                n_state = S_RM0;
                            end else if (i_req.func == FN_RM_TAIL) begin
                                rd_en   = 1'b1;
                                rd_addr = r_tail[IW-1:0];
                                n_cur   = r_tail;
                                n_state = S_RM0;
                            end else if (i_req.anchor_key == '0) begin
                                fin        = 1'b1;
                                fin_status = ST_NOTFOUND;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_head[IW-1:0];
                                n_cur   = r_head;
                                n_steps = '0;
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // The count is below SLOTS here, so a free slot always exists.
                if (!r_valid[r_idx]) begin
                    n_pv = r_idx;
                    if (r_req.func == FN_INS_AFTER) begin
                        rd_en   = 1'b1;
                        rd_addr = r_head[IW-1:0];
                        n_cur   = r_head;
                        n_steps = '0;
                        n_state = S_WALK;
                    end else begin
                        n_state = S_INS;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_WALK: begin
                // The entry at r_cur sits in the read register; the next read
                // is issued straight from its link field.
                if (walk_hit) begin
                    n_state = (r_req.func == FN_RM_KEY) ? S_RM0 : S_INS;
                end else if (is_nil(r_rd_q.next) || r_steps == IW'(SLOTS - 1)) begin
                    fin        = 1'b1;
                    fin_status = ST_NOTFOUND;
                    n_state    = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_rd_q.next[IW-1:0];
                    n_cur   = r_rd_q.next;
                    n_steps = r_steps + 1'b1;
                end
            end

            S_INS: begin
                wr_en          = 1'b1;
                wr_addr        = r_pv;
                n_valid[r_pv]  = 1'b1;
                n_count        = r_count + 1'b1;
                n_slot         = r_pv;
                if (is_nil(r_head)) begin
                    n_head  = LW'(r_pv);
                    n_tail  = LW'(r_pv);
                    fin     = 1'b1;
                    fin_use_slot = 1'b1;
                    n_state = S_IDLE;
                end else if (r_req.func == FN_INS_HEAD) begin
                    new_ent.next = r_head;
                    n_paddr = r_head[IW-1:0];
                    n_psel  = 1'b1;
                    n_head  = LW'(r_pv);
                    n_state = S_PATCH_RD;
                end else if (r_req.func == FN_INS_TAIL) begin
                    new_ent.prev = r_tail;
                    n_tail = LW'(r_pv);
                    if (!is_nil(r_tail)) begin
                        n_paddr = r_tail[IW-1:0];
                        n_psel  = 1'b0;
                        n_state = S_PATCH_RD;
                    end else begin
                        fin     = 1'b1;
                        fin_use_slot = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    new_ent.prev = r_cur;
                    new_ent.next = r_rd_q.next;
                    n_n     = r_rd_q.next;
                    n_state = S_ANCH_WR;
                end
                wr_data = new_ent;
            end

            S_ANCH_WR: begin
                // The anchor entry is still held in the read register.
                wr_en        = 1'b1;
                wr_addr      = r_cur[IW-1:0];
                wr_data      = r_rd_q;
                wr_data.next = LW'(r_pv);
                if (!is_nil(r_n)) begin
                    n_paddr = r_n[IW-1:0];
                    n_psel  = 1'b1;
                    n_state = S_PATCH_RD;
                end else begin
                    n_tail  = LW'(r_pv);
                    fin     = 1'b1;
                    fin_use_slot = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_PATCH_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_paddr;
                n_state = S_PATCH_WR;
            end

            S_PATCH_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_paddr;
                wr_data = r_rd_q;
                if (r_psel) begin
                    wr_data.prev = LW'(r_pv);
                end else begin
                    wr_data.next = LW'(r_pv);
                end
                fin     = 1'b1;
                fin_use_slot = 1'b1;
                n_state = S_IDLE;
            end

            S_RM0: begin
                n_p = r_rd_q.prev;
                n_n = r_rd_q.next;
                n_valid[r_cur[IW-1:0]] = 1'b0;
                n_count = r_count - 1'b1;
                n_slot  = r_cur[IW-1:0];
                if (!is_nil(r_rd_q.prev)) begin
                    rd_en   = 1'b1;
                    rd_addr = r_rd_q.prev[IW-1:0];
                    n_state = S_RM_P_WR;
                end else begin
                    n_head  = r_rd_q.next;
                    n_state = S_RM_N;
                end
            end

            S_RM_P_WR: begin
                wr_en        = 1'b1;
                wr_addr      = r_p[IW-1:0];
                wr_data      = r_rd_q;
                wr_data.next = r_n;
                n_state      = S_RM_N;
            end

            S_RM_N: begin
                if (!is_nil(r_n)) begin
                    rd_en   = 1'b1;
                    rd_addr = r_n[IW-1:0];
                    n_state = S_RM_N_WR;
                end else begin
                    n_tail  = r_p;
                    fin     = 1'b1;
                    fin_use_slot = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_RM_N_WR: begin
                wr_en        = 1'b1;
                wr_addr      = r_n[IW-1:0];
                wr_data      = r_rd_q;
                wr_data.prev = r_p;
                fin          = 1'b1;
                fin_use_slot = 1'b1;
                n_state      = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_valid_out        = fin;
        n_rsp              = r_rsp;
        if (fin) begin
            n_rsp.status       = fin_status;
            n_rsp.slot_touched = fin_use_slot ? SLOT_W'(n_slot) : '0;
            n_rsp.entry_count  = COUNT_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= NIL;
            r_tail      <= NIL;
            r_count     <= '0;
            r_valid     <= '0;
            r_valid_out <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_valid     <= n_valid;
            r_valid_out <= n_valid_out;
        end
        r_req   <= n_req;
        r_idx   <= n_idx;
        r_steps <= n_steps;
        r_cur   <= n_cur;
        r_pv    <= n_pv;
        r_slot  <= n_slot;
        r_paddr <= n_paddr;
        r_psel  <= n_psel;
        r_p     <= n_p;
        r_n     <= n_n;
        r_rsp   <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_q <= r_mem[rd_addr];
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid_out;
    assign o_rsp   = r_rsp;

    // The count always equals the number of occupied slots.
    a_count_matches_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(r_valid)))
        else $error("entry count differs from occupied slot count");

    // An empty list and a null head go together.
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == is_nil(r_head))
        else $error("head pointer disagrees with entry count");

    // The sequencer never reads an entry in the cycle it rewrites it.
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && wr_en && rd_addr == wr_addr))
        else $error("RAM read and write to the same slot in one cycle");

    // A result strobe follows only a taken request or a busy cycle.
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(start) && !$past(busy)) || $past(busy))
        else $error("result strobe without a request");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for indexed_doubly_linked_list: directed table, then random
// list traffic checked against a behavioral list model kept in this file.
// Depends on idll_pkg and the indexed_doubly_linked_list RTL.
`timescale 1ns / 1ps

module testbench;
    import idll_pkg::*;

    localparam int SLOTS = DEF_SLOTS;
    localparam int NIL = SLOTS;
    localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;
    localparam logic [KEY_W-1:0] KEY_MAX = 31'h7FFF_FFFF;
    localparam logic [PLATE_W-1:0] PLATE_ONES = '1;
    localparam int STATUS_CODES = 5;
    localparam int RANDOM_ITEMS = 1500;
    localparam int PHASES = 4;
    localparam int BURST = 40;
    localparam int KEY_POOL = 6;
    localparam int MAX_REPORTS = 10;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 20;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_req i_req = '0;
    logic busy;
    logic o_valid;
    t_rsp o_rsp;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    indexed_doubly_linked_list #(.SLOTS(SLOTS)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_valid(o_valid),
        .o_rsp  (o_rsp)
    );

    // Behavioral copy of the list: keys, links, head, tail and count.
    logic [KEY_W-1:0] key_tbl [SLOTS];
    int next_tbl [SLOTS];
    int prev_tbl [SLOTS];
    int head_idx = NIL;
    int tail_idx = NIL;
    int live_cnt = 0;

    t_rsp awaited_rsp [$];
    bit   pin_valid = 1'b0;
    t_rsp pin_rsp = '0;
    int   mismatches = 0;
    int   req_count = 0;
    int   rsp_count = 0;
    int   stall_cycles = 0;
    int   status_seen [STATUS_CODES];

    typedef struct {
        t_req req;
        int   reps;
        bit   pinned;
        t_rsp want;
    } t_row;

    t_row stim_rows [$];
    logic [KEY_W-1:0] key_pool [KEY_POOL];
    int idle_pct [PHASES] = '{0, 45, 0, 15};

    function automatic int locate_key(logic [KEY_W-1:0] k);
        int cur;
        cur = head_idx;
        if (k == '0) return NIL;
        for (int s = 0; s < SLOTS && cur < SLOTS; s++) begin
            if (key_tbl[cur] == k) return cur;
            cur = next_tbl[cur];
        end
        return NIL;
    endfunction

    function automatic t_rsp apply_list_op(t_req r);
        t_rsp o;
        int fs, anc, vic, nb, pv, slot;
        o.status = ST_OK;
        slot = 0;
        anc = NIL;
        if (r.func <= FN_INS_AFTER) begin
            fs = NIL;
            for (int i = SLOTS - 1; i >= 0; i--)
                if (key_tbl[i] == '0) fs = i;
            if (r.func == FN_INS_AFTER) anc = locate_key(r.anchor_key);
            // Fullness wins over a zero key, which wins over a missing anchor.
            if (live_cnt >= SLOTS || fs == NIL) begin
                o.status = ST_FULL;
            end else if (r.new_key == '0) begin
                o.status = ST_BADKEY;
            end else if (r.func == FN_INS_AFTER && anc == NIL) begin
                o.status = ST_NOTFOUND;
            end else begin
                key_tbl[fs] = r.new_key;
                if (head_idx == NIL) begin
                    head_idx = fs;
                    tail_idx = fs;
                    next_tbl[fs] = NIL;
                    prev_tbl[fs] = NIL;
                end else if (r.func == FN_INS_HEAD) begin
                    prev_tbl[head_idx] = fs;
                    next_tbl[fs] = head_idx;
                    prev_tbl[fs] = NIL;
                    head_idx = fs;
                end else if (r.func == FN_INS_TAIL) begin
                    if (tail_idx != NIL) next_tbl[tail_idx] = fs;
                    prev_tbl[fs] = tail_idx;
                    next_tbl[fs] = NIL;
                    tail_idx = fs;
                end else begin
                    nb = next_tbl[anc];
                    prev_tbl[fs] = anc;
                    next_tbl[fs] = nb;
                    if (nb != NIL) prev_tbl[nb] = fs;
                    else tail_idx = fs;
                    next_tbl[anc] = fs;
                end
                live_cnt++;
                slot = fs;
            end
        end else if (r.func <= FN_RM_KEY) begin
            if (live_cnt == 0 || head_idx == NIL) begin
                o.status = ST_EMPTY;
            end else begin
                if (r.func == FN_RM_HEAD) vic = head_idx;
                else if (r.func == FN_RM_TAIL) vic = tail_idx;
                else vic = locate_key(r.anchor_key);
                if (vic == NIL) begin
                    o.status = ST_NOTFOUND;
                end else begin
                    pv = prev_tbl[vic];
                    nb = next_tbl[vic];
                    if (pv != NIL) next_tbl[pv] = nb;
                    else head_idx = nb;
                    if (nb != NIL) prev_tbl[nb] = pv;
                    else tail_idx = pv;
                    next_tbl[vic] = NIL;
                    prev_tbl[vic] = NIL;
                    key_tbl[vic] = '0;
                    if (live_cnt > 0) live_cnt--;
                    slot = vic;
                end
            end
        end
        o.slot_touched = (o.status == ST_OK) ? SLOT_W'(slot) : '0;
        o.entry_count = COUNT_W'(live_cnt);
        return o;
    endfunction

    // Result checking, request capture and the progress watchdog.
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp model_rsp;
        bit took;
        took = 1'b0;
        if (i_rst_n) begin
            if (o_valid) begin
                took = 1'b1;
                rsp_count++;
                if (o_rsp.status <= ST_BADKEY) status_seen[o_rsp.status]++;
                if (awaited_rsp.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result with no request pending: %p", $time, o_rsp);
                end else begin
                    want = awaited_rsp.pop_front();
                    if (o_rsp.status !== want.status || o_rsp.slot_touched !== want.slot_touched
                            || o_rsp.entry_count !== want.entry_count) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: expected status %0d slot %0d count %0d, got %0d %0d %0d",
                                     $time, want.status, want.slot_touched, want.entry_count,
                                     o_rsp.status, o_rsp.slot_touched, o_rsp.entry_count);
                    end
                end
            end
            if (start && !busy) begin
                took = 1'b1;
                req_count++;
                model_rsp = apply_list_op(i_req);
                awaited_rsp.push_back(pin_valid ? pin_rsp : model_rsp);
            end
            stall_cycles = took ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no request or result for %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic issue(input t_req r, input bit pinned, input t_rsp want);
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        pin_valid <= pinned;
        pin_rsp <= want;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic sender_gap(input int pct);
        if ($urandom_range(0, 99) < pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge i_clk);
        end
    endtask

    task automatic hold_until_drained;
        @(negedge i_clk);
        start <= 1'b0;
        while (awaited_rsp.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_row(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] nk,
                           input logic [KEY_W-1:0] ak, input logic [PLATE_W-1:0] pl,
                           input logic [CLASS_W-1:0] cl, input int reps, input bit pinned,
                           input logic [STAT_W-1:0] st, input int slot, input int cnt);
        t_row row;
        row.req.func = fn;
        row.req.new_key = nk;
        row.req.anchor_key = ak;
        row.req.plate_payload = pl;
        row.req.vehicle_class = cl;
        row.reps = reps;
        row.pinned = pinned;
        row.want.status = st;
        row.want.slot_touched = SLOT_W'(slot);
        row.want.entry_count = COUNT_W'(cnt);
        stim_rows.push_back(row);
    endtask

    initial begin
        t_req r;
        t_rsp none;
        int ins_pct, sel, base;
        logic [KEY_W-1:0] live;
        none = '0;
        foreach (key_tbl[i]) begin
            key_tbl[i] = '0;
            next_tbl[i] = NIL;
            prev_tbl[i] = NIL;
        end
        foreach (status_seen[i]) status_seen[i] = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty-list rejections, bad key, missing anchor, the unused codes and the first inserts.
        add_row(FN_RM_HEAD, '0, '0, '0, 2'd0, 1, 1, ST_EMPTY, 0, 0);
        add_row(FN_RM_TAIL, '0, '0, PLATE_ONES, 2'd3, 1, 1, ST_EMPTY, 0, 0);
        add_row(FN_RM_KEY, '0, 31'd5, '0, 2'd0, 1, 1, ST_EMPTY, 0, 0);
        add_row(FN_INS_HEAD, '0, '0, PLATE_ONES, 2'd3, 1, 1, ST_BADKEY, 0, 0);
        add_row(FN_INS_AFTER, 31'd9, 31'd5, '0, 2'd1, 1, 1, ST_NOTFOUND, 0, 0);
        add_row(FN_SPARE_6, KEY_MAX, KEY_MAX, PLATE_ONES, 2'd3, 1, 1, ST_OK, 0, 0);
        add_row(FN_SPARE_7, KEY_MAX, KEY_MAX, PLATE_ONES, 2'd3, 1, 1, ST_OK, 0, 0);
        add_row(FN_INS_HEAD, KEY_MAX, '0, PLATE_ONES, 2'd3, 1, 1, ST_OK, 0, 1);
        add_row(FN_INS_TAIL, 31'd1, KEY_MAX, '0, 2'd0, 1, 1, ST_OK, 1, 2);
        add_row(FN_INS_AFTER, 31'h5555_5555, KEY_MAX, 56'h55_5555_5555_5555, 2'd2,
                1, 0, ST_OK, 0, 0);
        // An anchor or removal key of zero never matches.
        add_row(FN_INS_AFTER, 31'd3, '0, '0, 2'd1, 1, 1, ST_NOTFOUND, 0, 3);
        add_row(FN_RM_KEY, '0, '0, '0, 2'd0, 1, 1, ST_NOTFOUND, 0, 3);
        add_row(FN_RM_KEY, '0, 31'd12345, '0, 2'd0, 1, 1, ST_NOTFOUND, 0, 3);
        add_row(FN_RM_KEY, '0, 31'd1, '0, 2'd0, 1, 0, ST_OK, 0, 0);
        add_row(FN_INS_AFTER, 31'h2AAA_AAAA, 31'h5555_5555, 56'hAA_AAAA_AAAA_AAAA, 2'd1,
                1, 0, ST_OK, 0, 0);
        // Fill the table with duplicate keys, probe the full list, then remove and insert again.
        add_row(FN_INS_TAIL, 31'd7, '0, 56'h12_3456_789A_BCDE, 2'd2, SLOTS - 3, 0, ST_OK, 0, 0);
        add_row(FN_INS_HEAD, 31'd9, '0, '0, 2'd0, 1, 1, ST_FULL, 0, SLOTS);
        add_row(FN_INS_AFTER, '0, KEY_MAX, '0, 2'd0, 1, 1, ST_FULL, 0, SLOTS);
        add_row(FN_SPARE_6, '0, '0, '0, 2'd0, 1, 1, ST_OK, 0, SLOTS);
        add_row(FN_RM_KEY, '0, 31'd7, '0, 2'd0, 1, 0, ST_OK, 0, 0);
        add_row(FN_INS_HEAD, 31'h12, '0, PLATE_ONES, 2'd1, 1, 0, ST_OK, 0, 0);
        add_row(FN_RM_TAIL, '0, '0, '0, 2'd0, 1, 0, ST_OK, 0, 0);
        add_row(FN_RM_HEAD, '0, '0, '0, 2'd0, 1, 0, ST_OK, 0, 0);
        add_row(FN_RM_KEY, '0, KEY_MAX, '0, 2'd0, 1, 0, ST_OK, 0, 0);

        foreach (stim_rows[i])
            repeat (stim_rows[i].reps) issue(stim_rows[i].req, stim_rows[i].pinned,
                                             stim_rows[i].want);
        hold_until_drained;

        // Each phase idles the sender with its own chance from idle_pct; the first and
        // third phases run with no idling at all.
        for (int ph = 0; ph < PHASES; ph++) begin
            foreach (key_pool[i])
                do key_pool[i] = KEY_W'($urandom); while (key_pool[i] == '0);
            ins_pct = 50;
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                // Bursts lean toward inserts or removals so the list swings between
                // empty and full.
                if (n % BURST == 0) begin
                    case ($urandom_range(0, 2))
                        0: ins_pct = 25;
                        1: ins_pct = 50;
                        default: ins_pct = 80;
                    endcase
                end
                sel = $urandom_range(0, 99);
                if (sel < 4) begin
                    r.func = sel[0] ? FN_SPARE_7 : FN_SPARE_6;
                end else if ($urandom_range(0, 99) < ins_pct) begin
                    case ($urandom_range(0, 2))
                        0: r.func = FN_INS_HEAD;
                        1: r.func = FN_INS_TAIL;
                        default: r.func = FN_INS_AFTER;
                    endcase
                end else begin
                    case ($urandom_range(0, 2))
                        0: r.func = FN_RM_HEAD;
                        1: r.func = FN_RM_TAIL;
                        default: r.func = FN_RM_KEY;
                    endcase
                end
                sel = $urandom_range(0, 99);
                if (sel < 5) r.new_key = '0;
                else if (sel < 75) r.new_key = key_pool[$urandom_range(0, KEY_POOL - 1)];
                else r.new_key = KEY_W'($urandom);
                live = '0;
                base = $urandom_range(0, SLOTS - 1);
                for (int i = 0; i < SLOTS; i++)
                    if (live == '0) live = key_tbl[(base + i) % SLOTS];
                sel = $urandom_range(0, 99);
                if (sel < 60) r.anchor_key = live;
                else if (sel < 75) r.anchor_key = key_pool[$urandom_range(0, KEY_POOL - 1)];
                else if (sel < 85) r.anchor_key = '0;
                else r.anchor_key = KEY_W'($urandom);
                r.plate_payload = PLATE_W'({$urandom, $urandom});
                r.vehicle_class = CLASS_W'($urandom_range(0, 3));
                issue(r, 1'b0, none);
                sender_gap(idle_pct[ph]);
            end
            hold_until_drained;
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d requests and %0d results over %0d idling phases.",
                 req_count, rsp_count, PHASES);
        $display("Statuses seen: ok %0d, full %0d, empty %0d, not found %0d, bad key %0d.",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
                 status_seen[ST_NOTFOUND], status_seen[ST_BADKEY]);
        if (mismatches == 0 && awaited_rsp.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
